// ----- design/ccp_pkg.sv -----
// ----------------------------------------------------------------------------
// ccp_pkg: shared types for the capsule closest-point block
// Word layouts of the query and result channels, and fixed field widths.
// ----------------------------------------------------------------------------
package ccp_pkg;

    localparam int COORD_W  = 32;
    localparam int RADIUS_W = COORD_W - 1;
    localparam int THR_W    = 32;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] start_z;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic signed [COORD_W-1:0] end_z;
        logic        [RADIUS_W-1:0] radius;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } query_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] closest_x;
        logic signed [COORD_W-1:0] closest_y;
        logic signed [COORD_W-1:0] closest_z;
    } result_t;

endpackage

// ----- design/capsule_closest_point.sv -----
// ----------------------------------------------------------------------------
// capsule_closest_point: closest point on a capsule to a query point
// Each query word holds a capsule (axis start, axis end, radius) and a point;
// each result word holds the closest point, saturated, in the same format.
//
// Channels: query (query_valid/query_stall/query) in, result
// (result_valid/result_stall/result) out, and a threshold write channel
// (thr_valid/thr_ready/thr_data), always ready, for the zero threshold.
// Throughput: one word per cycle while the result side does not stall. The
// pipeline depth is set by the projection divider (one bit per stage),
// the square root (one bit per stage) and the offset divider.
// The pipeline advances as one; a stall on the result side holds every
// stage and the stall is passed straight back to the query side, so no
// word is lost or repeated. Bubbles travel as cleared valid bits.
// Reset clears the valid bits and sets the threshold to zero.
// The user must write the threshold only while the block is empty; the block does not enforce this.
// ----------------------------------------------------------------------------
module capsule_closest_point #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          query_valid,
    output logic                          query_stall,
    input  ccp_pkg::query_t               query,
    output logic                          result_valid,
    input  logic                          result_stall,
    output ccp_pkg::result_t              result,
    input  logic                          thr_valid,
    output logic                          thr_ready,
    input  logic [ccp_pkg::THR_W-1:0]     thr_data
);

    import ccp_pkg::*;

    localparam int W   = COORD_W;
    localparam int TF  = 2 * FRAC_BITS;
    localparam int DW  = W + 1;
    localparam int MW  = W + 1;
    localparam int PW  = 2 * MW;
    localparam int LW  = PW + 2;
    localparam int TW  = TF + 1;
    localparam int PAW = MW + TW;
    localparam int AW  = W + 2;
    localparam int RW  = RADIUS_W;
    localparam int RRW = 2 * RW;
    localparam int RB  = LW / 2;
    localparam int OPW = MW + RW;
    localparam int NB  = OPW + 1;
    localparam int QB  = W + 1;
    localparam int CW  = AW + 1;
    localparam int TNB = LW + TF;
    localparam logic [PAW:0] HALF = (PAW + 1)'(1) << (TF - 1);

    typedef struct packed {
        logic [2:0][W-1:0]  s;
        logic [2:0][DW-1:0] d;
        logic [2:0][W-1:0]  p;
        logic [RW-1:0]      r;
        logic               t_zero;
        logic               t_one;
    } axis_side_t;

    typedef struct packed {
        logic [2:0][AW-1:0] a;
        logic [2:0]         v_neg;
        logic [2:0][MW-1:0] v_mag;
        logic [RW-1:0]      r;
        logic               mv;
    } sq_side_t;

    typedef struct packed {
        logic [2:0][AW-1:0] a;
        logic [2:0]         v_neg;
        logic               mv;
    } off_side_t;

    function automatic logic [MW-1:0] abs_dw(input logic signed [DW-1:0] x);
        abs_dw = x[DW-1] ? MW'(-x) : MW'(x);
    endfunction

    function automatic logic [MW-1:0] abs_aw(input logic signed [AW-1:0] x);
        abs_aw = x[AW-1] ? MW'(-x) : MW'(x);
    endfunction

    logic adv;
    logic [THR_W-1:0] thr_reg;

    logic signed [W-1:0] q_s [3];
    logic signed [W-1:0] q_e [3];
    logic signed [W-1:0] q_p [3];

    // stage 1: differences
    logic                 v1_reg;
    logic signed [W-1:0]  s1_s_reg [3];
    logic signed [W-1:0]  s1_p_reg [3];
    logic signed [DW-1:0] s1_d_reg [3];
    logic signed [DW-1:0] s1_w_reg [3];
    logic [RW-1:0]        s1_r_reg;
    // stage 2: products
    logic                 v2_reg;
    logic [PW-1:0]        s2_dd_next [3];
    logic [PW-1:0]        s2_wd_next [3];
    logic [2:0]           s2_neg_next;
    logic [PW-1:0]        s2_dd_reg [3];
    logic [PW-1:0]        s2_wd_reg [3];
    logic [2:0]           s2_neg_reg;
    logic signed [W-1:0]  s2_s_reg [3];
    logic signed [W-1:0]  s2_p_reg [3];
    logic signed [DW-1:0] s2_d_reg [3];
    logic [RW-1:0]        s2_r_reg;
    // stage 3: sums
    logic                 v3_reg;
    logic [LW-1:0]        s3_len_next;
    logic [LW-1:0]        s3_pos_next;
    logic [LW-1:0]        s3_neg_next;
    logic [LW-1:0]        s3_len_reg;
    logic [LW-1:0]        s3_pos_reg;
    logic [LW-1:0]        s3_neg_reg;
    logic signed [W-1:0]  s3_s_reg [3];
    logic signed [W-1:0]  s3_p_reg [3];
    logic signed [DW-1:0] s3_d_reg [3];
    logic [RW-1:0]        s3_r_reg;
    // projection divider
    logic [LW-1:0]        t_num;
    logic                 t_zero;
    logic                 t_one;
    logic [TNB-1:0]       tdiv_num [1];
    axis_side_t           tdiv_side_in;
    axis_side_t           tdiv_side;
    logic                 tdiv_valid;
    logic [TF-1:0]        tdiv_quo [1];
    // stage 5: axis scaling
    logic                 v5_reg;
    logic [TW-1:0]        t_val;
    logic [PAW-1:0]       s5_pa_next [3];
    logic [PAW-1:0]       s5_pa_reg [3];
    logic [2:0]           s5_dneg_reg;
    logic signed [W-1:0]  s5_s_reg [3];
    logic signed [W-1:0]  s5_p_reg [3];
    logic [RW-1:0]        s5_r_reg;
    // stage 6: axis point
    logic                 v6_reg;
    logic signed [AW-1:0] s6_a_next [3];
    logic signed [AW-1:0] s6_v_next [3];
    logic signed [AW-1:0] s6_a_reg [3];
    logic signed [AW-1:0] s6_v_reg [3];
    logic [RW-1:0]        s6_r_reg;
    // stage 7: squares
    logic                 v7_reg;
    logic [MW-1:0]        s7_vmag_next [3];
    logic [PW-1:0]        s7_vv_next [3];
    logic [PW-1:0]        s7_vv_reg [3];
    logic [MW-1:0]        s7_vmag_reg [3];
    logic [2:0]           s7_vneg_reg;
    logic signed [AW-1:0] s7_a_reg [3];
    logic [RRW-1:0]       s7_rr_reg;
    logic [RW-1:0]        s7_r_reg;
    // square root
    logic [LW-1:0]        q_sum;
    sq_side_t             sq_side_in;
    sq_side_t             sq_side;
    logic                 sq_valid;
    logic [RB-1:0]        sq_root;
    // stage 9: offset products
    logic                 v9_reg;
    logic [OPW-1:0]       s9_prod_reg [3];
    logic [RB-1:0]        s9_dist_reg;
    logic signed [AW-1:0] s9_a_reg [3];
    logic [2:0]           s9_vneg_reg;
    logic                 s9_mv_reg;
    // offset divider
    logic [NB-1:0]        odiv_num [3];
    off_side_t            odiv_side_in;
    off_side_t            odiv_side;
    logic                 odiv_valid;
    logic [QB-1:0]        odiv_quo [3];
    // output
    logic                 result_valid_reg;
    result_t              result_reg;
    result_t              result_next;

    assign adv         = !result_valid_reg || !result_stall;
    assign query_stall = !adv;
    assign thr_ready   = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else if (thr_valid)
        begin
            thr_reg <= thr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            v3_reg           <= 1'b0;
            v5_reg           <= 1'b0;
            v6_reg           <= 1'b0;
            v7_reg           <= 1'b0;
            v9_reg           <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg           <= query_valid;
            v2_reg           <= v1_reg;
            v3_reg           <= v2_reg;
            v5_reg           <= tdiv_valid;
            v6_reg           <= v5_reg;
            v7_reg           <= v6_reg;
            v9_reg           <= sq_valid;
            result_valid_reg <= odiv_valid;
        end
    end

    assign q_s[0] = query.start_x;
    assign q_s[1] = query.start_y;
    assign q_s[2] = query.start_z;
    assign q_e[0] = query.end_x;
    assign q_e[1] = query.end_y;
    assign q_e[2] = query.end_z;
    assign q_p[0] = query.point_x;
    assign q_p[1] = query.point_y;
    assign q_p[2] = query.point_z;

    always_comb
    begin
        logic [MW-1:0] d_mag;
        logic [MW-1:0] w_mag;
        d_mag = '0;
        w_mag = '0;
        for (int i = 0; i < 3; i++)
        begin
            d_mag          = abs_dw(s1_d_reg[i]);
            w_mag          = abs_dw(s1_w_reg[i]);
            s2_dd_next[i]  = d_mag * d_mag;
            s2_wd_next[i]  = w_mag * d_mag;
            s2_neg_next[i] = s1_w_reg[i][DW-1] ^ s1_d_reg[i][DW-1];
        end
    end

    always_comb
    begin
        s3_len_next = LW'(s2_dd_reg[0]) + LW'(s2_dd_reg[1]) + LW'(s2_dd_reg[2]);
        s3_pos_next = '0;
        s3_neg_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (s2_neg_reg[i])
            begin
                s3_neg_next = s3_neg_next + LW'(s2_wd_reg[i]);
            end
            else
            begin
                s3_pos_next = s3_pos_next + LW'(s2_wd_reg[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_s_reg[i] <= q_s[i];
                s1_p_reg[i] <= q_p[i];
                s1_d_reg[i] <= DW'(q_e[i]) - DW'(q_s[i]);
                s1_w_reg[i] <= DW'(q_p[i]) - DW'(q_s[i]);
                s2_dd_reg[i] <= s2_dd_next[i];
                s2_wd_reg[i] <= s2_wd_next[i];
                s2_s_reg[i]  <= s1_s_reg[i];
                s2_p_reg[i]  <= s1_p_reg[i];
                s2_d_reg[i]  <= s1_d_reg[i];
                s3_s_reg[i]  <= s2_s_reg[i];
                s3_p_reg[i]  <= s2_p_reg[i];
                s3_d_reg[i]  <= s2_d_reg[i];
            end
            s1_r_reg   <= query.radius;
            s2_neg_reg <= s2_neg_next;
            s2_r_reg   <= s1_r_reg;
            s3_len_reg <= s3_len_next;
            s3_pos_reg <= s3_pos_next;
            s3_neg_reg <= s3_neg_next;
            s3_r_reg   <= s2_r_reg;
        end
    end

    // t = 0 for a degenerate axis or a projection before the start
    assign t_zero = (s3_len_reg <= LW'(thr_reg)) || (s3_pos_reg <= s3_neg_reg);
    assign t_num  = s3_pos_reg - s3_neg_reg;
    assign t_one  = !t_zero && (t_num >= s3_len_reg);
    assign tdiv_num[0] = {t_num, {TF{1'b0}}};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            tdiv_side_in.s[i] = s3_s_reg[i];
            tdiv_side_in.d[i] = s3_d_reg[i];
            tdiv_side_in.p[i] = s3_p_reg[i];
        end
        tdiv_side_in.r      = s3_r_reg;
        tdiv_side_in.t_zero = t_zero;
        tdiv_side_in.t_one  = t_one;
    end

    ccp_div #(
        .NB    (TNB),
        .DB    (LW),
        .QB    (TF),
        .LANES (1),
        .SW    ($bits(axis_side_t))
    ) u_tdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v3_reg),
        .num       (tdiv_num),
        .den       (s3_len_reg),
        .side_in   (tdiv_side_in),
        .out_valid (tdiv_valid),
        .quo       (tdiv_quo),
        .side_out  (tdiv_side)
    );

    always_comb
    begin
        if (tdiv_side.t_zero)
        begin
            t_val = '0;
        end
        else if (tdiv_side.t_one)
        begin
            t_val = {1'b1, {TF{1'b0}}};
        end
        else
        begin
            t_val = {1'b0, tdiv_quo[0]};
        end
        for (int i = 0; i < 3; i++)
        begin
            s5_pa_next[i] = abs_dw($signed(tdiv_side.d[i])) * t_val;
        end
    end

    // axis point rounds half away from zero
    always_comb
    begin
        logic [PAW:0]  rnd;
        logic [MW-1:0] sh;
        rnd = '0;
        sh  = '0;
        for (int i = 0; i < 3; i++)
        begin
            rnd = {1'b0, s5_pa_reg[i]} + HALF;
            sh  = rnd[TF +: MW];
            if (s5_dneg_reg[i])
            begin
                s6_a_next[i] = AW'(s5_s_reg[i]) - $signed({1'b0, sh});
            end
            else
            begin
                s6_a_next[i] = AW'(s5_s_reg[i]) + $signed({1'b0, sh});
            end
            s6_v_next[i] = AW'(s5_p_reg[i]) - s6_a_next[i];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s7_vmag_next[i] = abs_aw(s6_v_reg[i]);
            s7_vv_next[i]   = s7_vmag_next[i] * s7_vmag_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s5_pa_reg[i]   <= s5_pa_next[i];
                s5_dneg_reg[i] <= tdiv_side.d[i][DW-1];
                s5_s_reg[i]    <= $signed(tdiv_side.s[i]);
                s5_p_reg[i]    <= $signed(tdiv_side.p[i]);
                s6_a_reg[i]    <= s6_a_next[i];
                s6_v_reg[i]    <= s6_v_next[i];
                s7_vv_reg[i]   <= s7_vv_next[i];
                s7_vmag_reg[i] <= s7_vmag_next[i];
                s7_vneg_reg[i] <= s6_v_reg[i][AW-1];
                s7_a_reg[i]    <= s6_a_reg[i];
            end
            s5_r_reg  <= tdiv_side.r;
            s6_r_reg  <= s5_r_reg;
            s7_r_reg  <= s6_r_reg;
            s7_rr_reg <= s6_r_reg * s6_r_reg;
        end
    end

    assign q_sum = LW'(s7_vv_reg[0]) + LW'(s7_vv_reg[1]) + LW'(s7_vv_reg[2]);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_side_in.a[i]     = s7_a_reg[i];
            sq_side_in.v_neg[i] = s7_vneg_reg[i];
            sq_side_in.v_mag[i] = s7_vmag_reg[i];
        end
        sq_side_in.r  = s7_r_reg;
        // outside the surface and clear of the near-zero band
        sq_side_in.mv = (q_sum > LW'(s7_rr_reg)) && (q_sum > LW'(thr_reg));
    end

    ccp_sqrt #(
        .XW (LW),
        .SW ($bits(sq_side_t))
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v7_reg),
        .x         (q_sum),
        .side_in   (sq_side_in),
        .out_valid (sq_valid),
        .root      (sq_root),
        .side_out  (sq_side)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s9_prod_reg[i] <= sq_side.v_mag[i] * sq_side.r;
                s9_a_reg[i]    <= $signed(sq_side.a[i]);
                s9_vneg_reg[i] <= sq_side.v_neg[i];
            end
            s9_dist_reg <= sq_root;
            s9_mv_reg   <= sq_side.mv && (sq_root != '0);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            odiv_num[i]        = NB'(s9_prod_reg[i]) + NB'(s9_dist_reg >> 1);
            odiv_side_in.a[i]  = s9_a_reg[i];
        end
        odiv_side_in.v_neg = s9_vneg_reg;
        odiv_side_in.mv    = s9_mv_reg;
    end

    ccp_div #(
        .NB    (NB),
        .DB    (RB),
        .QB    (QB),
        .LANES (3),
        .SW    ($bits(off_side_t))
    ) u_odiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v9_reg),
        .num       (odiv_num),
        .den       (s9_dist_reg),
        .side_in   (odiv_side_in),
        .out_valid (odiv_valid),
        .quo       (odiv_quo),
        .side_out  (odiv_side)
    );

    // final move toward the point, then saturate
    always_comb
    begin
        logic signed [CW-1:0] c;
        logic signed [CW-1:0] off;
        logic [W-1:0]         sat [3];
        c   = '0;
        off = '0;
        for (int i = 0; i < 3; i++)
        begin
            off = $signed(CW'(odiv_quo[i]));
            c   = CW'($signed(odiv_side.a[i]));
            if (odiv_side.mv)
            begin
                c = odiv_side.v_neg[i] ? c - off : c + off;
            end
            if (!c[CW-1] && (|c[CW-2:W-1]))
            begin
                sat[i] = {1'b0, {(W-1){1'b1}}};
            end
            else if (c[CW-1] && !(&c[CW-2:W-1]))
            begin
                sat[i] = {1'b1, {(W-1){1'b0}}};
            end
            else
            begin
                sat[i] = c[W-1:0];
            end
        end
        result_next.closest_x = sat[0];
        result_next.closest_y = sat[1];
        result_next.closest_z = sat[2];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
        query_stall |-> (result_valid && result_stall))
        else $error("query side stalled without a blocked result");

    a_dist_covers_radius: assert property (@(posedge clk) disable iff (!rst_n)
        (sq_valid && sq_side.mv) |-> (sq_root >= RB'(sq_side.r)))
        else $error("distance below radius on a point marked outside");

endmodule

// ----- design/ccp_div.sv -----
// ----------------------------------------------------------------------------
// ccp_div: pipelined restoring divider
// One quotient bit per stage, LANES numerators over a shared divisor, with a
// sideband word carried alongside. Quotient must fit in QB bits.
// ----------------------------------------------------------------------------
module ccp_div #(
    parameter int NB    = 64,
    parameter int DB    = 32,
    parameter int QB    = 32,
    parameter int LANES = 1,
    parameter int SW    = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NB-1:0] num [LANES],
    input  logic [DB-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [QB-1:0] quo [LANES],
    output logic [SW-1:0] side_out
);

    logic [QB:0]   valid_reg;
    logic [DB-1:0] rem_reg  [QB+1][LANES];
    logic [DB-1:0] rem_next [QB+1][LANES];
    logic [QB-1:0] low_reg  [QB+1][LANES];
    logic [QB-1:0] low_next [QB+1][LANES];
    logic [QB-1:0] quo_reg  [QB+1][LANES];
    logic [QB-1:0] quo_next [QB+1][LANES];
    logic [DB-1:0] den_reg  [QB+1];
    logic [SW-1:0] side_reg [QB+1];

    always_comb
    begin
        logic [DB:0] trial;
        logic        ge;
        trial = '0;
        ge    = 1'b0;
        for (int l = 0; l < LANES; l++)
        begin
            rem_next[0][l] = DB'(num[l] >> QB);
            low_next[0][l] = num[l][QB-1:0];
            quo_next[0][l] = '0;
        end
        for (int k = 0; k < QB; k++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                trial = {rem_reg[k][l], low_reg[k][l][QB-1]};
                ge    = trial >= {1'b0, den_reg[k]};
                rem_next[k+1][l] = ge ? DB'(trial - {1'b0, den_reg[k]}) : DB'(trial);
                low_next[k+1][l] = low_reg[k][l] << 1;
                quo_next[k+1][l] = {quo_reg[k][l][QB-2:0], ge};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[QB-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg[0]  <= den;
            side_reg[0] <= side_in;
            for (int k = 0; k < QB; k++)
            begin
                den_reg[k+1]  <= den_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
            for (int k = 0; k <= QB; k++)
            begin
                rem_reg[k] <= rem_next[k];
                low_reg[k] <= low_next[k];
                quo_reg[k] <= quo_next[k];
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            quo[l] = quo_reg[QB][l];
        end
    end

    assign out_valid = valid_reg[QB];
    assign side_out  = side_reg[QB];

endmodule

// ----- design/ccp_sqrt.sv -----
// ----------------------------------------------------------------------------
// ccp_sqrt: pipelined integer square root
// Floor of the square root, one root bit per stage, sideband carried along.
// ----------------------------------------------------------------------------
module ccp_sqrt #(
    parameter int XW = 68,
    parameter int SW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [XW-1:0]   x,
    input  logic [SW-1:0]   side_in,
    output logic            out_valid,
    output logic [XW/2-1:0] root,
    output logic [SW-1:0]   side_out
);

    localparam int RB = XW / 2;

    logic [RB:0]   valid_reg;
    logic [XW-1:0] x_reg     [RB+1];
    logic [XW-1:0] x_next    [RB+1];
    logic [RB:0]   rem_reg   [RB+1];
    logic [RB:0]   rem_next  [RB+1];
    logic [RB-1:0] root_reg  [RB+1];
    logic [RB-1:0] root_next [RB+1];
    logic [SW-1:0] side_reg  [RB+1];

    always_comb
    begin
        logic [RB+2:0] cur;
        logic [RB+2:0] trial;
        logic          ge;
        cur   = '0;
        trial = '0;
        ge    = 1'b0;
        x_next[0]    = x;
        rem_next[0]  = '0;
        root_next[0] = '0;
        for (int k = 0; k < RB; k++)
        begin
            cur   = {rem_reg[k], x_reg[k][XW-1:XW-2]};
            trial = {1'b0, root_reg[k], 2'b01};
            ge    = cur >= trial;
            rem_next[k+1]  = ge ? (RB+1)'(cur - trial) : (RB+1)'(cur);
            root_next[k+1] = {root_reg[k][RB-2:0], ge};
            x_next[k+1]    = x_reg[k] << 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[RB-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int k = 0; k < RB; k++)
            begin
                side_reg[k+1] <= side_reg[k];
            end
            for (int k = 0; k <= RB; k++)
            begin
                x_reg[k]    <= x_next[k];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
            end
        end
    end

    assign out_valid = valid_reg[RB];
    assign root      = root_reg[RB];
    assign side_out  = side_reg[RB];

endmodule

// ----- verif/tb_capsule_closest_point.sv -----
// ----------------------------------------------------------------------------
// tb_capsule_closest_point: self-checking bench for the capsule block
// Drives capsule/point queries with random idling on both sides, predicts
// each result word with an exact fixed-point model of the projection, clamp
// and radius offset, and checks results in order. The zero threshold is
// rewritten between phases while the block is empty.
// ----------------------------------------------------------------------------
class ccp_scoreboard;

    ccp_pkg::result_t pending[$];
    logic [31:0]      threshold;
    int               errors;

    function new();
        threshold = '0;
        errors    = 0;
    endfunction

    static function logic [63:0] isqrt(logic [127:0] n);
        logic [63:0]  res;
        logic [63:0]  c;
        begin
            res = '0;
            for (int b = 63; b >= 0; b--)
            begin
                c = res | (64'd1 << b);
                if (128'(c) * 128'(c) <= n)
                    res = c;
            end
            return res;
        end
    endfunction

    function ccp_pkg::result_t closest(ccp_pkg::query_t q);
        logic signed [63:0] s[3], e[3], p[3], d[3], a[3], v[3], c;
        logic [127:0]       len, pos, neg, num, qd, rr, nm;
        logic [63:0]        t, r, root, off, dm, wm;
        logic signed [63:0] w;
        ccp_pkg::result_t   res;
        begin
            s[0] = q.start_x; s[1] = q.start_y; s[2] = q.start_z;
            e[0] = q.end_x;   e[1] = q.end_y;   e[2] = q.end_z;
            p[0] = q.point_x; p[1] = q.point_y; p[2] = q.point_z;
            r = 64'(q.radius);
            len = '0; pos = '0; neg = '0; t = '0; qd = '0;
            for (int i = 0; i < 3; i++)
            begin
                d[i] = e[i] - s[i];
                w = p[i] - s[i];
                dm = d[i] < 0 ? -d[i] : d[i];
                wm = w < 0 ? -w : w;
                len += 128'(dm) * 128'(dm);
                if ((w < 0) != (d[i] < 0))
                    neg += 128'(wm) * 128'(dm);
                else
                    pos += 128'(wm) * 128'(dm);
            end
            if (len > 128'(threshold) && pos > neg)
            begin
                num = pos - neg;
                if (num >= len)
                    t = 64'd1 << 32;
                else
                    t = 64'((num << 32) / len);
            end
            for (int i = 0; i < 3; i++)
            begin
                dm = d[i] < 0 ? -d[i] : d[i];
                nm = (128'(dm) * 128'(t) + (128'd1 << 31)) >> 32;
                a[i] = d[i] < 0 ? s[i] - 64'(nm) : s[i] + 64'(nm);
                v[i] = p[i] - a[i];
                wm = v[i] < 0 ? -v[i] : v[i];
                qd += 128'(wm) * 128'(wm);
            end
            rr = 128'(r) * 128'(r);
            if (qd > rr && qd > 128'(threshold))
            begin
                root = isqrt(qd);
                if (root != 0)
                    for (int i = 0; i < 3; i++)
                    begin
                        wm = v[i] < 0 ? -v[i] : v[i];
                        nm = 128'(wm) * 128'(r) + 128'(root >> 1);
                        off = 64'(nm / 128'(root));
                        a[i] = v[i] < 0 ? a[i] - off : a[i] + off;
                    end
            end
            for (int i = 0; i < 3; i++)
            begin
                c = a[i];
                if (c > 64'sd2147483647) c = 64'sd2147483647;
                if (c < -64'sd2147483648) c = -64'sd2147483648;
                case (i)
                    0: res.closest_x = c[31:0];
                    1: res.closest_y = c[31:0];
                    default: res.closest_z = c[31:0];
                endcase
            end
            return res;
        end
    endfunction

    function void note_query(ccp_pkg::query_t q);
        pending.push_back(closest(q));
    endfunction

    function void check_result(ccp_pkg::result_t got);
        ccp_pkg::result_t exp;
        begin
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result word %h", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.closest_x !== exp.closest_x)
            begin
                $display("%0t: closest_x expected %h got %h", $time, exp.closest_x,
                         got.closest_x);
                errors++;
            end
            if (got.closest_y !== exp.closest_y)
            begin
                $display("%0t: closest_y expected %h got %h", $time, exp.closest_y,
                         got.closest_y);
                errors++;
            end
            if (got.closest_z !== exp.closest_z)
            begin
                $display("%0t: closest_z expected %h got %h", $time, exp.closest_z,
                         got.closest_z);
                errors++;
            end
        end
    endfunction

endclass

module tb_capsule_closest_point;

    localparam int LATENCY = 110;

    logic             clk;
    logic             rst_n;
    logic             query_valid;
    logic             query_stall;
    ccp_pkg::query_t  query;
    logic             result_valid;
    logic             result_stall;
    ccp_pkg::result_t result;
    logic             thr_valid;
    logic             thr_ready;
    logic [31:0]      thr_data;
    logic             sink_on;

    ccp_scoreboard sb;

    capsule_closest_point DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .query_valid  (query_valid),
        .query_stall  (query_stall),
        .query        (query),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .thr_valid    (thr_valid),
        .thr_ready    (thr_ready),
        .thr_data     (thr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #50000000;
        $display("TEST FAILED");
        $finish;
    end

    // result side: random stall per word, checks at acceptance
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result);
    end

    initial
    begin
        int n;
        result_stall = 1'b1;
        @(posedge clk iff rst_n);
        forever
        begin
            n = $urandom_range(0, 4);
            if (!sink_on || ($urandom_range(0, 3) == 0))
                n = 0;
            if (n > 0)
            begin
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            result_stall <= 1'b0;
            @(posedge clk iff result_valid);
        end
    end

    function automatic logic signed [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return $signed($urandom_range(0, 2000)) - 1000;
            2: return $signed($urandom_range(0, 32'h40000)) - 32'sh20000;
            default: return $signed($urandom_range(0, 32'h4000000)) - 32'sh2000000;
        endcase
    endfunction

    function automatic ccp_pkg::query_t rand_query();
        ccp_pkg::query_t q;
        int m;
        begin
            m = $urandom_range(0, 3);
            q.start_x = rand_coord(m); q.start_y = rand_coord(m);
            q.start_z = rand_coord(m);
            if ($urandom_range(0, 9) == 0)
            begin
                q.end_x = q.start_x + rand_coord(1) % 3;
                q.end_y = q.start_y; q.end_z = q.start_z;
            end
            else
            begin
                q.end_x = rand_coord(m); q.end_y = rand_coord(m);
                q.end_z = rand_coord(m);
            end
            case ($urandom_range(0, 3))
                0: q.radius = 31'($urandom());
                1: q.radius = 31'($urandom_range(0, 64));
                default: q.radius = 31'($urandom_range(0, 32'h30000));
            endcase
            q.point_x = rand_coord(m); q.point_y = rand_coord(m);
            q.point_z = rand_coord(m);
            return q;
        end
    endfunction

    task automatic send_query(ccp_pkg::query_t q);
        int n;
        begin
            n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
            if (n > 0)
            begin
                query_valid <= 1'b0;
                repeat (n) @(posedge clk);
            end
            query_valid <= 1'b1;
            query       <= q;
            @(posedge clk iff !query_stall);
            sb.note_query(q);
        end
    endtask

    task automatic drain();
        begin
            query_valid <= 1'b0;
            @(posedge clk iff sb.pending.size() == 0);
            repeat (LATENCY + 10) @(posedge clk);
        end
    endtask

    task automatic write_threshold(logic [31:0] value);
        begin
            thr_valid <= 1'b1;
            thr_data  <= value;
            @(posedge clk iff thr_ready);
            thr_valid <= 1'b0;
            sb.threshold = value;
        end
    endtask

    task automatic send_box(logic signed [31:0] sx, logic signed [31:0] ex,
                            logic signed [31:0] r, logic signed [31:0] px,
                            logic signed [31:0] py);
        ccp_pkg::query_t q;
        begin
            q = '0;
            q.start_x = sx; q.end_x = ex; q.radius = r[30:0];
            q.point_x = px; q.point_y = py;
            send_query(q);
        end
    endtask

    localparam logic signed [31:0] MAXC = 32'sh7fffffff;
    localparam logic signed [31:0] MINC = 32'sh80000000;
    localparam logic signed [31:0] ONE  = 32'sh00010000;

    initial
    begin
        ccp_pkg::query_t q;
        logic [31:0] thr_set[4];
        sb = new();
        rst_n = 1'b0;
        query_valid = 1'b0;
        query = '0;
        thr_valid = 1'b0;
        thr_data = '0;
        sink_on = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words
        send_box(0, 10 * ONE, ONE, -5 * ONE, 3 * ONE);       // before start
        send_box(0, 10 * ONE, ONE, 15 * ONE, 3 * ONE);       // past end
        send_box(0, 10 * ONE, ONE, 4 * ONE + 7, 3 * ONE);    // interior t
        send_box(0, 10 * ONE, 4 * ONE, 4 * ONE, 3 * ONE);    // inside
        send_box(0, 10 * ONE, 3 * ONE, 4 * ONE, 3 * ONE);    // on surface
        send_box(ONE, ONE, ONE, 5 * ONE, 5 * ONE);           // degenerate axis
        send_box(0, 10 * ONE, 0, 4 * ONE, 0);                // on axis, r = 0
        send_box(0, 10 * ONE, 0, 4 * ONE, 1);                // tiny distance
        send_box(MINC, MAXC, MAXC, MAXC, MINC);
        send_box(MAXC, MINC, MAXC, MINC, MAXC);
        send_box(MAXC, MAXC, MAXC, MINC, MINC);
        send_box(MINC, MINC, MAXC, MAXC, MAXC);
        send_box(MINC, MAXC, 0, 0, MAXC);
        q.start_x = MAXC; q.start_y = MINC; q.start_z = -1;
        q.end_x = MINC; q.end_y = MAXC; q.end_z = 1;
        q.radius = 31'h55555555;
        q.point_x = -1; q.point_y = 0; q.point_z = MAXC;
        send_query(q);
        q = ~q;
        send_query(q);
        sink_on = 1'b1;
        drain();

        thr_set[0] = 32'hffffffff;
        thr_set[1] = 32'h00000010;
        thr_set[2] = 32'h00000000;
        thr_set[3] = $urandom();
        for (int ph = 0; ph < 4; ph++)
        begin
            write_threshold(thr_set[ph]);
            if (ph == 0)
            begin
                send_box(0, 0, 0, 0, 0);                     // near-zero axis
                send_box(0, 1, 0, 0, 5);                     // short axis, small q
                send_box(0, 10 * ONE, 0, 4 * ONE, 8);
            end
            for (int k = 0; k < 235; k++)
            begin
                send_query(rand_query());
                if (k == 100)
                begin
                    query_valid <= 1'b0;
                    @(posedge clk iff sb.pending.size() == 0);
                end
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
